// File: rtl/srt_pkg.sv
`default_nettype none
package srt_pkg;

	localparam int unsigned DEF_TABLE_DEPTH = 16;

	localparam logic [2:0] FN_ADD    = 3'd0;
	localparam logic [2:0] FN_REMOVE = 3'd1;
	localparam logic [2:0] FN_FIND   = 3'd2;
	localparam logic [2:0] FN_CLEAR  = 3'd3;
	localparam logic [2:0] FN_READ   = 3'd4;

	typedef struct packed {
		logic [31:0] gw;
		logic [31:0] mask;
		logic [31:0] net;
	} srt_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_R_RD,
		ST_R_CHK,
		ST_D_RD,
		ST_D_WR,
		ST_A_FULL,
		ST_P_RD,
		ST_P_CHK,
		ST_U_RD,
		ST_U_WR,
		ST_F_RD,
		ST_F_CHK,
		ST_X_WAIT,
		ST_DONE
	} srt_state_t;

	typedef enum logic [1:0] {
		RD_P,
		RD_PM1,
		RD_IDX
	} srt_rdsel_t;

	typedef struct packed {
		logic       ld_op;
		logic       p_clr;
		logic       p_inc;
		logic       p_dec;
		logic       p_to_cnt;
		logic       pos_to_p;
		logic       cnt_clr;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       rd_en;
		srt_rdsel_t rd_sel;
		logic       wr_en;
		logic       wr_prev;
		logic       wr_new;
		logic       mark;
		logic       mark_ok;
		logic       mark_hit;
		logic       res_load;
	} srt_cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       p_eq_cnt;
		logic       p_eq_pos;
		logic       rem_hit;
		logic       pre_hit;
		logic       find_hit;
		logic       idx_ok;
		logic       full;
		logic       res_busy;
	} srt_sts_t;

	// a has a set bit below the lowest set bit of b: prefix of a is longer
	function automatic logic longer(input logic [31:0] a, input logic [31:0] b);
		return (a & ~b & (b - 32'd1)) != 32'd0;
	endfunction

endpackage
`default_nettype wire

// File: rtl/srt_ctrl.sv
`default_nettype none
module srt_ctrl
	import srt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire srt_sts_t sts,
	output srt_cmd_t      cmd
);

	srt_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		cmd.rd_sel = RD_P;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_op = 1'b1;
					cmd.p_clr = 1'b1;
					state_nx  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				priority if (sts.func == FN_ADD || sts.func == FN_REMOVE) begin
					state_nx = ST_R_RD;
				end else if (sts.func == FN_FIND) begin
					state_nx = ST_F_RD;
				end else if (sts.func == FN_CLEAR) begin
					cmd.cnt_clr = 1'b1;
					cmd.mark    = 1'b1;
					cmd.mark_ok = 1'b1;
					state_nx    = ST_DONE;
				end else if (sts.func == FN_READ && sts.idx_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
					state_nx   = ST_X_WAIT;
				end else begin
					cmd.mark = 1'b1;
					state_nx = ST_DONE;
				end
			end
			// look for an exact match to delete
			ST_R_RD: begin
				if (sts.p_eq_cnt) begin
					if (sts.func == FN_ADD) begin
						state_nx = ST_A_FULL;
					end else begin
						cmd.mark = 1'b1;
						state_nx = ST_DONE;
					end
				end else begin
					cmd.rd_en = 1'b1;
					state_nx  = ST_R_CHK;
				end
			end
			ST_R_CHK: begin
				cmd.p_inc = 1'b1;
				state_nx  = sts.rem_hit ? ST_D_RD : ST_R_RD;
			end
			// close the gap
			ST_D_RD: begin
				if (sts.p_eq_cnt) begin
					cmd.cnt_dec = 1'b1;
					if (sts.func == FN_ADD) begin
						state_nx = ST_A_FULL;
					end else begin
						cmd.mark    = 1'b1;
						cmd.mark_ok = 1'b1;
						state_nx    = ST_DONE;
					end
				end else begin
					cmd.rd_en = 1'b1;
					state_nx  = ST_D_WR;
				end
			end
			ST_D_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_prev = 1'b1;
				cmd.p_inc   = 1'b1;
				state_nx    = ST_D_RD;
			end
			ST_A_FULL: begin
				if (sts.full) begin
					cmd.mark = 1'b1;
					state_nx = ST_DONE;
				end else begin
					cmd.p_clr = 1'b1;
					state_nx  = ST_P_RD;
				end
			end
			// find the insert position
			ST_P_RD: begin
				if (sts.p_eq_cnt) begin
					cmd.pos_to_p = 1'b1;
					state_nx     = ST_U_RD;
				end else begin
					cmd.rd_en = 1'b1;
					state_nx  = ST_P_CHK;
				end
			end
			ST_P_CHK: begin
				if (sts.pre_hit) begin
					cmd.pos_to_p = 1'b1;
					cmd.p_to_cnt = 1'b1;
					state_nx     = ST_U_RD;
				end else begin
					cmd.p_inc = 1'b1;
					state_nx  = ST_P_RD;
				end
			end
			// shift the tail up by one, then drop the new word in
			ST_U_RD: begin
				if (sts.p_eq_pos) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_new  = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.mark    = 1'b1;
					cmd.mark_ok = 1'b1;
					state_nx    = ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PM1;
					state_nx   = ST_U_WR;
				end
			end
			ST_U_WR: begin
				cmd.wr_en = 1'b1;
				cmd.p_dec = 1'b1;
				state_nx  = ST_U_RD;
			end
			ST_F_RD: begin
				if (sts.p_eq_cnt) begin
					cmd.mark = 1'b1;
					state_nx = ST_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					state_nx  = ST_F_CHK;
				end
			end
			ST_F_CHK: begin
				if (sts.find_hit) begin
					cmd.mark     = 1'b1;
					cmd.mark_ok  = 1'b1;
					cmd.mark_hit = 1'b1;
					state_nx     = ST_DONE;
				end else begin
					cmd.p_inc = 1'b1;
					state_nx  = ST_F_RD;
				end
			end
			ST_X_WAIT: begin
				cmd.mark     = 1'b1;
				cmd.mark_ok  = 1'b1;
				cmd.mark_hit = 1'b1;
				state_nx     = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.res_busy) begin
					cmd.res_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/srt_dp.sv
`default_nettype none
module srt_dp
	import srt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [103:0] in_data,
	input  wire srt_cmd_t     cmd,
	output srt_sts_t          sts,
	input  wire logic         out_ready,
	output logic              out_valid,
	output logic [103:0]      out_data
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned IW = (CW > 4) ? CW : 4;

	srt_entry_t mem [TABLE_DEPTH];

	logic [2:0]  func_q;
	logic [31:0] addr_q, mask_q, gw_q;
	logic [3:0]  idx_q;
	logic [CW-1:0] p_q, pos_q, cnt_q;
	srt_entry_t  rdata_q;
	logic        ok_q, hit_q;
	logic        out_valid_q, out_ok_q;
	logic [95:0] out_route_q;

	logic [CW-1:0] pm1;
	logic [AW-1:0] rd_addr, wr_addr;
	srt_entry_t    wr_data;

	assign pm1 = p_q - 1'b1;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_P:    rd_addr = p_q[AW-1:0];
			RD_PM1:  rd_addr = pm1[AW-1:0];
			RD_IDX:  rd_addr = AW'(idx_q);
			default: rd_addr = p_q[AW-1:0];
		endcase
		wr_addr = cmd.wr_prev ? pm1[AW-1:0] : p_q[AW-1:0];
		if (cmd.wr_new) begin
			wr_data.net  = addr_q & mask_q;
			wr_data.mask = mask_q;
			wr_data.gw   = gw_q;
		end else begin
			wr_data = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (cmd.ld_op) begin
			func_q <= in_data[2:0];
			addr_q <= in_data[34:3];
			mask_q <= in_data[66:35];
			gw_q   <= in_data[98:67];
			idx_q  <= in_data[102:99];
		end
		if (cmd.mark) begin
			ok_q  <= cmd.mark_ok;
			hit_q <= cmd.mark_hit;
		end
		if (cmd.pos_to_p) begin
			pos_q <= p_q;
		end
		if (cmd.res_load) begin
			out_ok_q    <= ok_q;
			out_route_q <= hit_q ? {rdata_q.gw, rdata_q.mask, rdata_q.net} : 96'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			priority if (cmd.p_clr) begin
				p_q <= '0;
			end else if (cmd.p_to_cnt) begin
				p_q <= cnt_q;
			end else if (cmd.p_inc) begin
				p_q <= p_q + 1'b1;
			end else if (cmd.p_dec) begin
				p_q <= pm1;
			end
			priority if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.func     = func_q;
		sts.p_eq_cnt = (p_q == cnt_q);
		sts.p_eq_pos = (p_q == pos_q);
		sts.rem_hit  = (rdata_q.net == addr_q) && (rdata_q.mask == mask_q);
		sts.pre_hit  = longer(mask_q, rdata_q.mask);
		sts.find_hit = ((addr_q ^ rdata_q.net) & rdata_q.mask) == 32'd0;
		sts.idx_ok   = IW'(idx_q) < IW'(cnt_q);
		sts.full     = (cnt_q == CW'(TABLE_DEPTH));
		sts.res_busy = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = {7'd0, out_route_q, out_ok_q};

endmodule
`default_nettype wire

// File: rtl/sorted_route_table.sv
// channel  dir  tdata fields (lsb first)                               width
// s_axis   in   func[2:0] addr[31:0] netmask[31:0] gateway[31:0]        104
//               entry_index[3:0], 1 zero pad bit
// m_axis   out  ok route_addr[31:0] route_mask[31:0] route_gw[31:0],    104
//               7 zero pad bits
//
// one word at a time; a scan step is a table read, then a check
// remove scans for an exact match and closes the gap; add does the same, then
// finds the insert position and shifts the tail up when the table is not full
// the single-port table memory sets the pace
// reset empties the table at once, stored entries are not cleared
// a result waits in the output register while the next word is taken in
`default_nettype none
module sorted_route_table
	import srt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [103:0] s_axis_tdata,  // func, addr, netmask, gateway, entry_index
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [103:0]      m_axis_tdata   // ok, route_addr, route_mask, route_gw
);

	srt_cmd_t cmd;
	srt_sts_t sts;

	srt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

endmodule
`default_nettype wire

// File: rtl/srt_chk.sv
`default_nettype none
module srt_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [103:0] m_axis_tdata
);

	// a result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	// the block is busy right after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

	// a failed operation reports no route
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[96:1] == 96'd0)
		else $error("route fields set on failure");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[103:97] == 7'd0)
		else $error("pad bits set");

endmodule

bind sorted_route_table srt_chk u_srt_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: tb/sorted_route_table_tb.sv
module sorted_route_table_tb;
	import srt_pkg::*;

	localparam int DEPTH = 16;

	typedef struct packed {
		logic [3:0]  entry_index;
		logic [31:0] gateway;
		logic [31:0] netmask;
		logic [31:0] addr;
		logic [2:0]  func;
	} route_op_t;

	typedef struct packed {
		logic [31:0] route_gw;
		logic [31:0] route_mask;
		logic [31:0] route_addr;
		logic        ok;
	} route_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata;  // func, addr, netmask, gateway, entry_index, pad
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;  // ok, route_addr, route_mask, route_gw, pad

	sorted_route_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	route_op_t  pending_ops[$];
	route_res_t expected_routes[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int words_in = 0;
	int words_out = 0;
	int full_rejects = 0;
	int find_hits = 0;
	int cyc = 0;

	// shadow copy of the table
	logic [31:0] tbl_net[DEPTH];
	logic [31:0] tbl_mask[DEPTH];
	logic [31:0] tbl_gw[DEPTH];
	int          tbl_count = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int plen(logic [31:0] m);
		int tz;
		tz = 0;
		if (m == 32'd0)
			return 0;
		while (m[0] == 1'b0) begin
			m = m >> 1;
			tz++;
		end
		return 32 - tz;
	endfunction

	function automatic bit tbl_remove(logic [31:0] net, logic [31:0] mask);
		for (int k = 0; k < tbl_count; k++) begin
			if (tbl_net[k] == net && tbl_mask[k] == mask) begin
				for (int j = k + 1; j < tbl_count; j++) begin
					tbl_net[j-1] = tbl_net[j];
					tbl_mask[j-1] = tbl_mask[j];
					tbl_gw[j-1] = tbl_gw[j];
				end
				tbl_count--;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic route_res_t route_predict(route_op_t op);
		route_res_t r;
		int pos;
		bit dummy;
		r = '0;
		case (op.func)
			FN_ADD: begin
				dummy = tbl_remove(op.addr, op.netmask);
				if (tbl_count >= DEPTH) begin
					full_rejects++;
				end else begin
					pos = tbl_count;
					for (int k = 0; k < tbl_count; k++) begin
						if (plen(op.netmask) > plen(tbl_mask[k])) begin
							pos = k;
							break;
						end
					end
					for (int k = tbl_count; k > pos; k--) begin
						tbl_net[k] = tbl_net[k-1];
						tbl_mask[k] = tbl_mask[k-1];
						tbl_gw[k] = tbl_gw[k-1];
					end
					tbl_net[pos] = op.addr & op.netmask;
					tbl_mask[pos] = op.netmask;
					tbl_gw[pos] = op.gateway;
					tbl_count++;
					r.ok = 1'b1;
				end
			end
			FN_REMOVE: r.ok = tbl_remove(op.addr, op.netmask);
			FN_FIND: begin
				for (int k = 0; k < tbl_count; k++) begin
					if ((op.addr & tbl_mask[k]) == (tbl_net[k] & tbl_mask[k])) begin
						r = '{tbl_gw[k], tbl_mask[k], tbl_net[k], 1'b1};
						find_hits++;
						break;
					end
				end
			end
			FN_CLEAR: begin
				tbl_count = 0;
				r.ok = 1'b1;
			end
			FN_READ: begin
				if (int'(op.entry_index) < tbl_count)
					r = '{tbl_gw[op.entry_index], tbl_mask[op.entry_index],
						tbl_net[op.entry_index], 1'b1};
			end
			default: ;
		endcase
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		route_op_t op;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				op = s_axis_tdata[102:0];
				expected_routes.push_back(route_predict(op));
				words_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {1'b0, pending_ops.pop_front()};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	logic hold_off;
	always @(posedge clk) begin
		cyc <= cyc + 1;
		hold_off <= (cyc >= 4000 && cyc < 4600);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor
	always @(posedge clk) begin
		route_res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[96:0];
			words_out++;
			if (expected_routes.size() == 0) begin
				$error("result word with nothing expected: %h", got);
				errors++;
			end else begin
				want = expected_routes.pop_front();
				if (got.ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, got.ok);
					errors++;
				end
				if (got.route_addr !== want.route_addr) begin
					$error("route_addr: expected %h, got %h", want.route_addr, got.route_addr);
					errors++;
				end
				if (got.route_mask !== want.route_mask) begin
					$error("route_mask: expected %h, got %h", want.route_mask, got.route_mask);
					errors++;
				end
				if (got.route_gw !== want.route_gw) begin
					$error("route_gw: expected %h, got %h", want.route_gw, got.route_gw);
					errors++;
				end
			end
		end
	end

	function automatic route_op_t mk(logic [2:0] f, logic [31:0] a, logic [31:0] m,
			logic [31:0] g, logic [3:0] i);
		return '{i, g, m, a, f};
	endfunction

	function automatic logic [31:0] prefix_mask(int len);
		if (len == 0)
			return 32'd0;
		return 32'hffff_ffff << (32 - len);
	endfunction

	logic [31:0] addr_pool[8];

	function automatic route_op_t rand_op();
		route_op_t op;
		int sel;
		logic [31:0] a, m;
		sel = $urandom_range(99);
		a = ($urandom_range(3) == 0) ? $urandom : addr_pool[$urandom_range(7)];
		if ($urandom_range(7) == 0)
			m = $urandom;
		else
			m = prefix_mask($urandom_range(32));
		op = mk(FN_ADD, a, m, $urandom, $urandom_range(15));
		if (sel < 36)
			op.func = FN_ADD;
		else if (sel < 50) begin
			op.func = FN_REMOVE;
			if ($urandom_range(3) != 0)
				op.addr = a & m;
			if (tbl_count > 0 && $urandom_range(1) == 0) begin
				op.addr = tbl_net[$urandom_range(tbl_count - 1)];
				op.netmask = tbl_mask[$urandom_range(tbl_count - 1)];
			end
		end else if (sel < 80) begin
			op.func = FN_FIND;
			op.addr = a ^ ($urandom & ~m);
		end else if (sel < 93)
			op.func = FN_READ;
		else if (sel < 96)
			op.func = FN_CLEAR;
		else
			op.func = 3'($urandom_range(7, 5));
		return op;
	endfunction

	initial begin
		arst_n = 1'b0;
		m_axis_tready = 1'b0;
		hold_off = 1'b0;
		for (int k = 0; k < 8; k++)
			addr_pool[k] = {8'd10, 8'($urandom_range(3)), 8'($urandom_range(3)),
				8'($urandom_range(255))};
		addr_pool[6] = 32'hffff_ffff;
		addr_pool[7] = 32'h0000_0000;

		// directed: empty table, extremes, replacement, table full
		pending_ops.push_back(mk(FN_READ, '0, '0, '0, 4'd15));
		pending_ops.push_back(mk(FN_FIND, 32'hffff_ffff, '0, '0, '0));
		pending_ops.push_back(mk(FN_ADD, 32'h1234_5678, 32'h0, 32'hffff_ffff, '0));
		pending_ops.push_back(mk(FN_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'h1, '0));
		pending_ops.push_back(mk(FN_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'h2, '0));
		pending_ops.push_back(mk(FN_ADD, 32'h0a01_02ff, 32'hffff_ff00, 32'h3, '0));
		pending_ops.push_back(mk(FN_FIND, 32'h0a01_0203, '0, '0, '0));
		pending_ops.push_back(mk(FN_FIND, 32'hffff_ffff, '0, '0, '0));
		pending_ops.push_back(mk(FN_READ, '0, '0, '0, 4'd0));
		pending_ops.push_back(mk(FN_READ, '0, '0, '0, 4'd2));
		pending_ops.push_back(mk(FN_REMOVE, 32'h0a01_02ff, 32'hffff_ff00, '0, '0));
		pending_ops.push_back(mk(FN_REMOVE, 32'h0a01_0200, 32'hffff_ff00, '0, '0));
		pending_ops.push_back(mk(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 4'd15));
		pending_ops.push_back(mk(FN_CLEAR, '0, '0, '0, '0));
		for (int k = 0; k < 17; k++)
			pending_ops.push_back(mk(FN_ADD, 32'hc0a8_0000 + k, prefix_mask(16 + k),
				$urandom, '0));
		pending_ops.push_back(mk(FN_READ, '0, '0, '0, 4'd15));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 50 : 0;
			recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 27 : 0;
			for (int n = 0; n < 606; n++)
				pending_ops.push_back(rand_op_deferred());
			while (pending_ops.size() > 0)
				@(posedge clk);
		end
		while (s_axis_tvalid)
			@(posedge clk);
		while (expected_routes.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d words sent, %0d results checked, %0d finds hit, %0d adds on full table",
			words_in, words_out, find_hits, full_rejects);
		if (errors == 0 && expected_routes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// ops are generated ahead of prediction, so remove targets use a rough view
	function automatic route_op_t rand_op_deferred();
		return rand_op();
	endfunction

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
